FILE: design/alf_pkg.sv
// alf_pkg: shared types, codes and field widths of the ancestry leaf finder.
// No dependencies; every other design file but alf_cfg_if imports this package.
package alf_pkg;

    // Fixed field widths of the channel beats
    localparam int TERM_W  = 10;
    localparam int WSEL_W  = 4;
    localparam int ABITS_W = 64;
    localparam int POS_W   = 4;

    // Default sizing handed to the top level
    localparam int DEF_TERM_CNT  = 1024;
    localparam int DEF_MAX_SET   = 16;
    localparam int DEF_WORD_BITS = 64;

    // Fixed-point shift of the reciprocal used to split a term into word/bit
    localparam int RECIP_SHIFT = 20;

    // Input item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_PUSH  = 1'b1;

    // Output mode register codes
    localparam logic MODE_FLAG    = 1'b0;
    localparam logic MODE_COMPACT = 1'b1;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP1,
        ST_WRITE,
        ST_PREP2,
        ST_PUSH,
        ST_EVAL,
        ST_DRAIN,
        ST_SCAN,
        ST_EMIT,
        ST_NONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic prep1;
        logic write;
        logic prep2;
        logic push;
        logic eval_init;
        logic eval_issue;
        logic scan_init;
        logic scan_next;
        logic out_load;
        logic out_none;
        logic set_clear;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic func;
        logic last;
        logic last_pair;
        logic busy;
        logic any_leaf;
        logic cand;
        logic is_final;
        logic out_free;
        logic mode;
    } t_status;

endpackage

FILE: design/alf_in_if.sv
// alf_in_if: input channel of the ancestry leaf finder (matrix writes, set terms).
// Depends on alf_pkg for field widths.
interface alf_in_if;
    import alf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [TERM_W-1:0]    anc_row;
    logic [WSEL_W-1:0]    anc_word;
    logic [ABITS_W-1:0]   anc_bits;
    logic [TERM_W-1:0]    term;
    logic                 last;

    modport source (output valid, func, anc_row, anc_word, anc_bits, term, last,
                    input ready);
    modport sink   (input valid, func, anc_row, anc_word, anc_bits, term, last,
                    output ready);
endinterface

FILE: design/alf_out_if.sv
// alf_out_if: result channel of the ancestry leaf finder.
// Depends on alf_pkg for field widths.
interface alf_out_if;
    import alf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [TERM_W-1:0]    leaf_term;
    logic [POS_W-1:0]     position;
    logic                 is_leaf;
    logic                 none_found;
    logic                 overflow;
    logic                 last_out;

    modport source (output valid, leaf_term, position, is_leaf, none_found, overflow,
                    last_out, input ready);
    modport sink   (input valid, leaf_term, position, is_leaf, none_found, overflow,
                    last_out, output ready);
endinterface

FILE: design/alf_cfg_if.sv
// alf_cfg_if: configuration write channel carrying the output mode register.
// No dependencies beyond the language.
interface alf_cfg_if;
    logic valid;
    logic ready;
    logic output_mode;

    modport source (output valid, output_mode, input ready);
    modport sink   (input valid, output_mode, output ready);
endinterface

FILE: design/alf_dpath.sv
// alf_dpath: ancestry matrix memory, set store, pair-check pipeline and result register.
// Depends on alf_pkg; driven by alf_ctrl through t_cmd / t_status.
module alf_dpath #(
    parameter int TERM_CNT  = alf_pkg::DEF_TERM_CNT,
    parameter int MAX_SET   = alf_pkg::DEF_MAX_SET,
    parameter int WORD_BITS = alf_pkg::DEF_WORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  alf_pkg::t_cmd                i_cmd,
    output alf_pkg::t_status             o_sts,
    input  logic                         i_func,
    input  logic [alf_pkg::TERM_W-1:0]   i_anc_row,
    input  logic [alf_pkg::WSEL_W-1:0]   i_anc_word,
    input  logic [alf_pkg::ABITS_W-1:0]  i_anc_bits,
    input  logic [alf_pkg::TERM_W-1:0]   i_term,
    input  logic                         i_last,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_mode,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [alf_pkg::TERM_W-1:0]   o_leaf_term,
    output logic [alf_pkg::POS_W-1:0]    o_position,
    output logic                         o_is_leaf,
    output logic                         o_none_found,
    output logic                         o_overflow,
    output logic                         o_last_out
);
    import alf_pkg::*;

    localparam int WPR       = (TERM_CNT + WORD_BITS - 1) / WORD_BITS;
    localparam int MEM_WORDS = TERM_CNT * WPR;
    localparam int ADDR_W    = $clog2(MEM_WORDS);
    localparam int CWORD_W   = (WPR > 1) ? $clog2(WPR) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int IDX_W     = $clog2(MAX_SET);
    localparam int CNT_W     = $clog2(MAX_SET + 1);
    localparam int RECIP     = (1 << RECIP_SHIFT) / WORD_BITS;
    localparam int PROD_W    = TERM_W + RECIP_SHIFT;

    // One held set position with its precomputed matrix coordinates
    typedef struct packed {
        logic [TERM_W-1:0]  term;
        logic               in_range;
        logic [ADDR_W-1:0]  rowbase;
        logic [CWORD_W-1:0] cword;
        logic [BIT_W-1:0]   cbit;
    } t_entry;

    // Memories
    logic [WORD_BITS-1:0] r_anc_mem [MEM_WORDS];
    t_entry               r_set_mem [MAX_SET];
    logic [WORD_BITS-1:0] r_mem_q;
    t_entry               r_ent_a;
    t_entry               r_ent_b;

    // Captured beat and prep registers
    logic                 r_func;
    logic [TERM_W-1:0]    r_row;
    logic [WSEL_W-1:0]    r_wsel;
    logic [WORD_BITS-1:0] r_bits;
    logic [TERM_W-1:0]    r_term;
    logic                 r_last;
    logic [ADDR_W-1:0]    r_base;
    logic                 r_wr_ok;
    logic [PROD_W-1:0]    r_prod;
    logic [TERM_W-1:0]    r_q0;
    logic [TERM_W-1:0]    r_qd;

    // Control state
    logic                 r_mode;
    logic [CNT_W-1:0]     r_count;
    logic                 r_ovf;
    logic [MAX_SET-1:0]   r_leaf;
    logic [IDX_W-1:0]     r_p;
    logic [IDX_W-1:0]     r_q;
    logic                 r_s1_vld;
    logic                 r_s2_vld;
    logic                 r_ov;

    // Pipeline payload
    logic [IDX_W-1:0]     r_s1_p;
    logic [IDX_W-1:0]     r_s1_q;
    logic [IDX_W-1:0]     r_s2_p;
    logic                 r_s2_chk;
    logic                 r_s2_dup;
    logic [BIT_W-1:0]     r_s2_bit;

    // Result register payload
    logic [TERM_W-1:0]    r_o_term;
    logic [POS_W-1:0]     r_o_pos;
    logic                 r_o_leaf;
    logic                 r_o_none;
    logic                 r_o_ovf;
    logic                 r_o_last;

    logic [ADDR_W-1:0]    row_base;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic [TERM_W-1:0]    rem0;
    logic                 rem_fix;
    t_entry               push_entry;
    logic                 set_full;
    logic [IDX_W-1:0]     last_idx;
    logic                 kill;
    logic [MAX_SET-1:0]   pos_mask;
    logic [MAX_SET-1:0]   above_mask;
    logic [MAX_SET-1:0]   leaf_m;
    logic                 out_free;

    // Address arithmetic: row base, write address, pair read address
    assign row_base = ADDR_W'(r_row) * ADDR_W'(WPR);
    assign wr_addr  = r_base + ADDR_W'(r_wsel);
    assign rd_addr  = r_ent_a.rowbase + ADDR_W'(r_ent_b.cword);

    // Remainder correction: reciprocal quotient is exact or one low
    assign rem0    = r_term - r_qd;
    assign rem_fix = (rem0 >= TERM_W'(WORD_BITS));
    always_comb begin
        push_entry.term     = r_term;
        push_entry.in_range = (int'(r_term) < TERM_CNT);
        push_entry.rowbase  = r_base;
        push_entry.cword    = rem_fix ? CWORD_W'(r_q0 + TERM_W'(1)) : CWORD_W'(r_q0);
        push_entry.cbit     = rem_fix ? BIT_W'(rem0 - TERM_W'(WORD_BITS)) : BIT_W'(rem0);
    end

    assign set_full = (r_count >= CNT_W'(MAX_SET));
    assign last_idx = IDX_W'(r_count - CNT_W'(1));

    // Pair verdict: repeated earlier term or ancestor bit set
    assign kill = r_s2_dup || (r_s2_chk && r_mem_q[r_s2_bit]);

    // Position masks for leaf counting and last-leaf detection
    always_comb begin
        for (int i = 0; i < MAX_SET; i++) begin
            pos_mask[i]   = (i < int'(r_count));
            above_mask[i] = (i > int'(r_p));
        end
    end
    assign leaf_m   = r_leaf & pos_mask;
    assign out_free = !r_ov || i_out_ready;

    // Memories: ancestry matrix and set store, registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && r_wr_ok) begin
            r_anc_mem[wr_addr] <= r_bits;
        end
        r_mem_q <= r_anc_mem[rd_addr];
        if (i_cmd.push && !set_full) begin
            r_set_mem[r_count[IDX_W-1:0]] <= push_entry;
        end
        r_ent_a <= r_set_mem[r_p];
        r_ent_b <= r_set_mem[r_q];
    end

    // Input capture and term preparation
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_row  <= i_anc_row;
            r_wsel <= i_anc_word;
            r_bits <= i_anc_bits[WORD_BITS-1:0];
            r_term <= i_term;
            r_last <= i_last;
        end
        if (i_cmd.prep1) begin
            r_base  <= r_func ? ADDR_W'(r_term) * ADDR_W'(WPR) : row_base;
            r_wr_ok <= (int'(r_row) < TERM_CNT) && (int'(r_wsel) < WPR);
            r_prod  <= PROD_W'(r_term) * PROD_W'(RECIP);
        end
        if (i_cmd.prep2) begin
            r_q0 <= r_prod[RECIP_SHIFT +: TERM_W];
            r_qd <= r_prod[RECIP_SHIFT +: TERM_W] * TERM_W'(WORD_BITS);
        end
    end

    // Set bookkeeping, pair counters and check pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_FLAG;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_leaf   <= '0;
            r_p      <= '0;
            r_q      <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_mode;
            end
            if (i_cmd.push) begin
                if (set_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.set_clear) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            // pair walk, q inner, p outer; p doubles as result pointer
            if (i_cmd.eval_init || i_cmd.scan_init) begin
                r_p <= '0;
                r_q <= '0;
            end else if (i_cmd.eval_issue) begin
                if (r_q == last_idx) begin
                    r_q <= '0;
                    r_p <= r_p + IDX_W'(1);
                end else begin
                    r_q <= r_q + IDX_W'(1);
                end
            end else if (i_cmd.scan_next) begin
                r_p <= r_p + IDX_W'(1);
            end
            r_s1_vld <= i_cmd.eval_issue;
            r_s2_vld <= r_s1_vld;
            if (i_cmd.eval_init) begin
                r_leaf <= '1;
            end else if (r_s2_vld && kill) begin
                r_leaf[r_s2_p] <= 1'b0;
            end
        end
    end

    // Check pipeline payload
    always_ff @(posedge i_clk) begin
        r_s1_p   <= r_p;
        r_s1_q   <= r_q;
        r_s2_p   <= r_s1_p;
        r_s2_chk <= r_ent_a.in_range && r_ent_b.in_range && (r_s1_p != r_s1_q);
        r_s2_dup <= (r_ent_a.term == r_ent_b.term) && (r_s1_q < r_s1_p);
        r_s2_bit <= r_ent_b.cbit;
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load || i_cmd.out_none) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_term <= r_ent_a.term;
            r_o_pos  <= POS_W'(r_p);
            r_o_leaf <= r_leaf[r_p];
            r_o_none <= 1'b0;
            r_o_ovf  <= r_ovf;
            r_o_last <= o_sts.is_final;
        end else if (i_cmd.out_none) begin
            r_o_term <= '0;
            r_o_pos  <= '0;
            r_o_leaf <= 1'b0;
            r_o_none <= 1'b1;
            r_o_ovf  <= r_ovf;
            r_o_last <= 1'b1;
        end
    end

    // Status to controller
    always_comb begin
        o_sts.func      = r_func;
        o_sts.last      = r_last;
        o_sts.last_pair = (r_p == last_idx) && (r_q == last_idx);
        o_sts.busy      = r_s1_vld || r_s2_vld;
        o_sts.any_leaf  = |leaf_m;
        o_sts.cand      = (r_mode == MODE_FLAG) || r_leaf[r_p];
        o_sts.is_final  = (r_mode == MODE_FLAG) ? (r_p == last_idx)
                                                : !(|(leaf_m & above_mask));
        o_sts.out_free  = out_free;
        o_sts.mode      = r_mode;
    end

    assign o_out_valid  = r_ov;
    assign o_leaf_term  = r_o_term;
    assign o_position   = r_o_pos;
    assign o_is_leaf    = r_o_leaf;
    assign o_none_found = r_o_none;
    assign o_overflow   = r_o_ovf;
    assign o_last_out   = r_o_last;

endmodule

FILE: design/alf_ctrl.sv
// alf_ctrl: sequencing state machine of the ancestry leaf finder.
// Depends on alf_pkg for t_state, t_cmd, t_status and the code constants.
module alf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  alf_pkg::t_status i_sts,
    output alf_pkg::t_cmd    o_cmd
);
    import alf_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_PREP1;
            end
            ST_PREP1: begin
                n_state = (i_sts.func == FUNC_WRITE) ? ST_WRITE : ST_PREP2;
            end
            ST_WRITE: n_state = ST_IDLE;
            ST_PREP2: n_state = ST_PUSH;
            ST_PUSH: begin
                n_state = i_sts.last ? ST_EVAL : ST_IDLE;
            end
            ST_EVAL: begin
                if (i_sts.last_pair) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!i_sts.busy) begin
                    n_state = (i_sts.mode == MODE_COMPACT && !i_sts.any_leaf) ? ST_NONE
                                                                                : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.cand) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) n_state = i_sts.is_final ? ST_IDLE : ST_SCAN;
            end
            ST_NONE: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_PREP1: o_cmd.prep1 = 1'b1;
            ST_WRITE: o_cmd.write = 1'b1;
            ST_PREP2: o_cmd.prep2 = 1'b1;
            ST_PUSH: begin
                o_cmd.push      = 1'b1;
                o_cmd.eval_init = i_sts.last;
            end
            ST_EVAL: o_cmd.eval_issue = 1'b1;
            ST_DRAIN: o_cmd.scan_init = !i_sts.busy;
            ST_SCAN: o_cmd.scan_next = !i_sts.cand;
            ST_EMIT: begin
                o_cmd.out_load  = i_sts.out_free;
                o_cmd.set_clear = i_sts.out_free && i_sts.is_final;
                o_cmd.scan_next = i_sts.out_free && !i_sts.is_final;
            end
            ST_NONE: begin
                o_cmd.out_none  = i_sts.out_free;
                o_cmd.set_clear = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: design/ancestry_leaf_finder.sv
// ancestry_leaf_finder: top level, joins the controller and datapath to the channels.
// Depends on alf_pkg, alf_in_if, alf_out_if, alf_cfg_if, alf_ctrl and alf_dpath.
//
// Usage: the input channel i_in takes one beat per item. func = 0 writes one
// word of the ancestry matrix (anc_row, anc_word, anc_bits); func = 1 pushes
// term into the open set, and last = 1 closes the set and starts evaluation.
// Results leave on o_out, one beat per reported position; last_out marks the
// final beat of a set. i_cfg writes output_mode (always ready); the user must
// write it only while idle, as the block does not enforce this. Sequence: a
// matrix write passes the capture, prep and write states; a term passes the
// capture, first prep, second prep and push states. A closing term then checks every
// pair of the n terms held, one read each on the ancestry memory's single read port,
// drains the pipeline and emits results (compact: leaves only, or one none marker).
// The input is accepted only between items, one item at a time.
// Reset clears the set, the overflow flag, the mode (flag mode) and the result
// register valid flag; matrix contents are undefined until written.
// A stalled receiver holds the result register; the sequencer waits for it,
// and once the last result of a set is loaded the next item is accepted.
module ancestry_leaf_finder #(
    parameter int TERM_CNT  = alf_pkg::DEF_TERM_CNT,
    parameter int MAX_SET   = alf_pkg::DEF_MAX_SET,
    parameter int WORD_BITS = alf_pkg::DEF_WORD_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    alf_in_if.sink    i_in,
    alf_out_if.source o_out,
    alf_cfg_if.sink   i_cfg
);
    import alf_pkg::*;

    t_cmd    cmd;
    t_status sts;

    // Mode register always takes its beat
    assign i_cfg.ready = 1'b1;

    alf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    alf_dpath #(
        .TERM_CNT  (TERM_CNT),
        .MAX_SET   (MAX_SET),
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_func       (i_in.func),
        .i_anc_row    (i_in.anc_row),
        .i_anc_word   (i_in.anc_word),
        .i_anc_bits   (i_in.anc_bits),
        .i_term       (i_in.term),
        .i_last       (i_in.last),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_mode   (i_cfg.output_mode),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_leaf_term  (o_out.leaf_term),
        .o_position   (o_out.position),
        .o_is_leaf    (o_out.is_leaf),
        .o_none_found (o_out.none_found),
        .o_overflow   (o_out.overflow),
        .o_last_out   (o_out.last_out)
    );

endmodule

FILE: bench/tb.sv
// tb: self-checking bench for ancestry_leaf_finder; flag and compact modes.
// Depends on alf_pkg and the alf_in_if, alf_out_if and alf_cfg_if interfaces.
// A leaf predictor computes the expected result beats for every accepted item.
`timescale 1ns / 100ps

module tb;
    import alf_pkg::*;

    localparam int MAX_SET = DEF_MAX_SET;
    localparam int POOL_N  = 8;

    // One input item
    typedef struct packed {
        logic               func;
        logic [TERM_W-1:0]  anc_row;
        logic [WSEL_W-1:0]  anc_word;
        logic [ABITS_W-1:0] anc_bits;
        logic [TERM_W-1:0]  term;
        logic               last;
    } t_beat;

    // One result beat
    typedef struct packed {
        logic [TERM_W-1:0] leaf_term;
        logic [POS_W-1:0]  position;
        logic              is_leaf;
        logic              none_found;
        logic              overflow;
        logic              last_out;
    } t_leaf_rpt;

    // Directed row: item repeated rep times, last only on the final copy
    typedef struct {
        logic               mode;
        logic               func;
        logic [TERM_W-1:0]  anc_row;
        logic [WSEL_W-1:0]  anc_word;
        logic [ABITS_W-1:0] anc_bits;
        logic [TERM_W-1:0]  term;
        logic               last;
        int                 rep;
        logic               typed;
        t_leaf_rpt          want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    alf_in_if  in_ch ();
    alf_out_if out_ch ();
    alf_cfg_if cfg_ch ();

    ancestry_leaf_finder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state
    logic [ABITS_W-1:0] anc_mem [logic [13:0]];
    logic [TERM_W-1:0]  set_buf [MAX_SET];
    int                 set_n   = 0;
    logic               set_ovf = 1'b0;
    logic               out_mode = MODE_FLAG;

    t_leaf_rpt leaf_pred [$];
    t_leaf_rpt leaf_exp [$];
    t_leaf_rpt got_r;
    t_leaf_rpt want_r;
    int        mismatches = 0;
    bit        gaps_on = 1'b0;
    int        stall_left = 0;

    logic [TERM_W-1:0] pool [POOL_N];

    // Directed table: extremes, diagonal bit, repeats, overflow, none marker
    t_dir_row plan [19] = '{
        '{MODE_FLAG, FUNC_PUSH, 10'd0, 4'd0, 64'd0, 10'd1023, 1'b1, 1,
          1'b1, '{10'd1023, 4'd0, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{MODE_FLAG, FUNC_PUSH, 10'd0, 4'd0, 64'd0, 10'd0, 1'b1, 1,
          1'b1, '{10'd0, 4'd0, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{MODE_FLAG, FUNC_WRITE, 10'd0, 4'd15, '1, 10'd0, 1'b0, 1, 1'b0, '0},
        '{MODE_FLAG, FUNC_PUSH, 10'd0, 4'd0, 64'd0, 10'd0, 1'b0, 1, 1'b0, '0},
        '{MODE_FLAG, FUNC_PUSH, 10'd0, 4'd0, 64'd0, 10'd1023, 1'b1, 1, 1'b0, '0},
        '{MODE_FLAG, FUNC_WRITE, 10'd63, 4'd0, 64'h8000_0000_0000_0000, 10'd0, 1'b0, 1,
          1'b0, '0},
        '{MODE_FLAG, FUNC_PUSH, 10'd0, 4'd0, 64'd0, 10'd63, 1'b1, 2, 1'b0, '0},
        '{MODE_FLAG, FUNC_PUSH, 10'd0, 4'd0, 64'd0, 10'd63, 1'b1, 1,
          1'b1, '{10'd63, 4'd0, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{MODE_FLAG, FUNC_PUSH, 10'd0, 4'd0, 64'd0, 10'd341, 1'b1, 1, 1'b0, '0},
        '{MODE_COMPACT, FUNC_PUSH, 10'd0, 4'd0, 64'd0, 10'd63, 1'b1, 2,
          1'b1, '{10'd0, 4'd0, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{MODE_COMPACT, FUNC_PUSH, 10'd0, 4'd0, 64'd0, 10'd0, 1'b0, 1, 1'b0, '0},
        '{MODE_COMPACT, FUNC_PUSH, 10'd0, 4'd0, 64'd0, 10'd1023, 1'b1, 1, 1'b0, '0},
        '{MODE_COMPACT, FUNC_PUSH, 10'd0, 4'd0, 64'd0, 10'd512, 1'b1, 18,
          1'b1, '{10'd512, 4'd0, 1'b1, 1'b0, 1'b1, 1'b1}},
        '{MODE_COMPACT, FUNC_PUSH, 10'd0, 4'd0, 64'd0, 10'd341, 1'b0, 1, 1'b0, '0},
        '{MODE_COMPACT, FUNC_PUSH, 10'd0, 4'd0, 64'd0, 10'd682, 1'b1, 1, 1'b0, '0},
        '{MODE_COMPACT, FUNC_WRITE, 10'd341, 4'd10, 64'h0000_0400_0000_0000, 10'd0, 1'b0, 1,
          1'b0, '0},
        '{MODE_COMPACT, FUNC_PUSH, 10'd0, 4'd0, 64'd0, 10'd682, 1'b0, 1, 1'b0, '0},
        '{MODE_COMPACT, FUNC_PUSH, 10'd0, 4'd0, 64'd0, 10'd341, 1'b1, 1, 1'b0, '0},
        '{MODE_FLAG, FUNC_PUSH, 10'd0, 4'd0, 64'd0, 10'd682, 1'b1, 2, 1'b0, '0}
    };

    // Leaf predictor: updates matrix/set state, leaves this item's beats in leaf_pred
    function automatic void predict_leaves(input t_beat b);
        logic [13:0] key;
        logic        leaf [MAX_SET];
        int          n;
        int          nleaf;
        int          seen;
        int          p;
        int          q;

        leaf_pred.delete();
        if (b.func == FUNC_WRITE) begin
            anc_mem[{b.anc_row, b.anc_word}] = b.anc_bits;
            return;
        end
        if (set_n < MAX_SET) begin
            set_buf[set_n] = b.term;
            set_n++;
        end else begin
            set_ovf = 1'b1;
        end
        if (!b.last)
            return;

        // a position loses its leaf status to an earlier repeat or any ancestry bit
        n = set_n;
        nleaf = 0;
        for (p = 0; p < n; p++) begin
            leaf[p] = 1'b1;
            for (q = 0; q < n; q++) begin
                key = {set_buf[p], set_buf[q][9:6]};
                if (q < p && set_buf[q] == set_buf[p])
                    leaf[p] = 1'b0;
                if (q != p && anc_mem.exists(key) && anc_mem[key][set_buf[q][5:0]])
                    leaf[p] = 1'b0;
            end
            if (leaf[p])
                nleaf++;
        end

        seen = 0;
        if (out_mode == MODE_FLAG) begin
            for (p = 0; p < n; p++)
                leaf_pred.push_back('{set_buf[p], p[3:0], leaf[p], 1'b0, set_ovf,
                                      p == n - 1});
        end else if (nleaf == 0) begin
            leaf_pred.push_back('{10'd0, 4'd0, 1'b0, 1'b1, set_ovf, 1'b1});
        end else begin
            for (p = 0; p < n; p++) begin
                if (leaf[p]) begin
                    seen++;
                    leaf_pred.push_back('{set_buf[p], p[3:0], 1'b1, 1'b0, set_ovf,
                                          seen == nleaf});
                end
            end
        end
        set_n = 0;
        set_ovf = 1'b0;
    endfunction

    function automatic t_beat noise_beat();
        t_beat r;
        r.func     = 1'($urandom_range(1));
        r.anc_row  = TERM_W'($urandom_range(1023));
        r.anc_word = WSEL_W'($urandom_range(15));
        r.anc_bits = {$urandom, $urandom};
        r.term     = TERM_W'($urandom_range(1023));
        r.last     = 1'($urandom_range(1));
        return r;
    endfunction

    // Drive one item, wait for the beat, queue its expected results
    task automatic send(input t_beat b, input logic typed, input t_leaf_rpt want);
        if (gaps_on && $urandom_range(2) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.func     <= b.func;
        in_ch.anc_row  <= b.anc_row;
        in_ch.anc_word <= b.anc_word;
        in_ch.anc_bits <= b.anc_bits;
        in_ch.term     <= b.term;
        in_ch.last     <= b.last;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_leaves(b);
        if (typed)
            leaf_exp.push_back(want);
        else
            foreach (leaf_pred[j]) leaf_exp.push_back(leaf_pred[j]);
    endtask

    // Mode register write, only once the block has gone quiet
    task automatic set_mode(input logic m);
        in_ch.valid <= 1'b0;
        while (leaf_exp.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.output_mode <= m;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        out_mode = m;
    endtask

    // Result receiver with random stall bursts
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (gaps_on && $urandom_range(3) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 10);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_r = '{out_ch.leaf_term, out_ch.position, out_ch.is_leaf, out_ch.none_found,
                      out_ch.overflow, out_ch.last_out};
            if (leaf_exp.size() == 0) begin
                $error("unexpected result beat: leaf_term %0d position %0d",
                       got_r.leaf_term, got_r.position);
                mismatches++;
            end else begin
                want_r = leaf_exp.pop_front();
                if (got_r.leaf_term != want_r.leaf_term) begin
                    $error("leaf_term: expected %0d, got %0d", want_r.leaf_term,
                           got_r.leaf_term);
                    mismatches++;
                end
                if (got_r.position != want_r.position) begin
                    $error("position: expected %0d, got %0d", want_r.position,
                           got_r.position);
                    mismatches++;
                end
                if (got_r.is_leaf != want_r.is_leaf) begin
                    $error("is_leaf: expected %0d, got %0d", want_r.is_leaf, got_r.is_leaf);
                    mismatches++;
                end
                if (got_r.none_found != want_r.none_found) begin
                    $error("none_found: expected %0d, got %0d", want_r.none_found,
                           got_r.none_found);
                    mismatches++;
                end
                if (got_r.overflow != want_r.overflow) begin
                    $error("overflow: expected %0d, got %0d", want_r.overflow,
                           got_r.overflow);
                    mismatches++;
                end
                if (got_r.last_out != want_r.last_out) begin
                    $error("last_out: expected %0d, got %0d", want_r.last_out,
                           got_r.last_out);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        t_beat             b;
        logic [TERM_W-1:0] col;
        int                n;
        int                k;
        int                items;
        int                phase;

        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.func         <= FUNC_WRITE;
        in_ch.anc_row      <= '0;
        in_ch.anc_word     <= '0;
        in_ch.anc_bits     <= '0;
        in_ch.term         <= '0;
        in_ch.last         <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.output_mode <= MODE_FLAG;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_mode(MODE_FLAG);

        // Term pool: fixed corners plus random picks inside the corners' column words,
        // so the zeroing pass below stays short; sets only use pool terms
        pool[0] = 10'd0;
        pool[1] = 10'd1023;
        pool[2] = 10'd63;
        pool[3] = 10'd512;
        pool[4] = 10'd341;
        pool[5] = 10'd682;
        for (k = 6; k < POOL_N; k++) begin
            col     = pool[$urandom_range(5)];
            pool[k] = {col[9:6], 6'($urandom_range(63))};
        end

        // Zero every matrix word a pool pair can look up, so no read hits an unwritten word
        b = '0;
        b.func = FUNC_WRITE;
        foreach (pool[r]) begin
            foreach (pool[c]) begin
                b.anc_row  = pool[r];
                b.anc_word = pool[c][9:6];
                if (!anc_mem.exists({b.anc_row, b.anc_word}))
                    send(b, 1'b0, '0);
            end
        end

        // Directed table
        gaps_on = 1'b1;
        foreach (plan[i]) begin
            if (plan[i].mode != out_mode)
                set_mode(plan[i].mode);
            b.func     = plan[i].func;
            b.anc_row  = plan[i].anc_row;
            b.anc_word = plan[i].anc_word;
            b.anc_bits = plan[i].anc_bits;
            b.term     = plan[i].term;
            for (k = 0; k < plan[i].rep; k++) begin
                b.last = plan[i].last && (k == plan[i].rep - 1);
                send(b, plan[i].typed && b.last, plan[i].want);
            end
        end

        // Random phases, alternating modes; the last one runs without gaps
        for (phase = 0; phase < 4; phase++) begin
            set_mode(phase[0] ? MODE_COMPACT : MODE_FLAG);
            gaps_on = (phase != 3);
            items = 0;
            while (items < 6) begin
                if ($urandom_range(3) == 0) begin
                    // matrix write; mostly sparse words on pool rows
                    b = noise_beat();
                    b.func = FUNC_WRITE;
                    if ($urandom_range(4) != 0) begin
                        col        = pool[$urandom_range(POOL_N - 1)];
                        b.anc_row  = pool[$urandom_range(POOL_N - 1)];
                        b.anc_word = col[9:6];
                        b.anc_bits = {$urandom, $urandom} & {$urandom, $urandom}
                                     & {$urandom, $urandom};
                        b.anc_bits[col[5:0]] = 1'($urandom_range(1));
                    end
                    send(b, 1'b0, '0);
                    items++;
                end else begin
                    // a whole set, now and then past capacity
                    n = ($urandom_range(11) == 0) ? $urandom_range(17, 19)
                                                  : $urandom_range(1, 6);
                    for (k = 0; k < n; k++) begin
                        b = noise_beat();
                        b.func = FUNC_PUSH;
                        b.term = pool[$urandom_range(POOL_N - 1)];
                        b.last = (k == n - 1);
                        send(b, 1'b0, '0);
                    end
                    items += n;
                end
            end
        end

        // Drain and verdict
        in_ch.valid <= 1'b0;
        while (leaf_exp.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && leaf_exp.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
